FILE: rtl/core/lsm_pkg.sv
// Shared types, register codes and the axis stop test for the limit switch monitor.
// Used by lsm_filter and limit_switch_monitor_top; has no dependencies.
`timescale 1ns / 1ps

package lsm_pkg;

	localparam int VEC_W = 13;
	localparam int AXES = 3;
	localparam int SETTLE_W = 4;
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 4'd7;
	localparam logic [1:0] BOTH_HIT = 2'b11;

	localparam int SW_XMIN  = 0;
	localparam int SW_YMIN  = 1;
	localparam int SW_ZMIN  = 2;
	localparam int SW_PROBE = 3;
	localparam int SW_XMAX  = 4;
	localparam int SW_YMAX  = 5;
	localparam int SW_ZMAX  = 6;
	localparam int SW_X2MIN = 7;
	localparam int SW_X2MAX = 8;
	localparam int SW_Y2MIN = 9;
	localparam int SW_Y2MAX = 10;
	localparam int SW_Z2MIN = 11;
	localparam int SW_Z2MAX = 12;

	typedef enum logic [2:0] {
		REG_INVERT_MASK  = 3'd0,
		REG_CHECKING     = 3'd1,
		REG_PROBE_EN     = 3'd2,
		REG_DUAL_MASK    = 3'd3,
		REG_PROBE_MODE   = 3'd4,
		REG_FILTER_ON    = 3'd5,
		REG_SETTLE_TICKS = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PROBE_NONE     = 2'd0,
		PROBE_SHARED   = 2'd1,
		PROBE_SEPARATE = 2'd2
	} probe_mode_t;

	typedef struct packed {
		logic [VEC_W-1:0]    invert_mask;
		logic                checking_enabled;
		logic                probe_enabled;
		logic [AXES-1:0]     dual_axis_mask;
		logic [1:0]          probe_mode;
		logic                filter_on;
		logic [SETTLE_W-1:0] settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic [VEC_W-1:0] hits;
		logic [AXES-1:0]  stop;
	} check_t;

	// Returns {stop, hit} for one axis side.
	function automatic logic [1:0] side_test(logic prim, logic second, logic dual,
			logic homing);
		logic hit;
		logic stop;
		begin
			if (dual) begin
				hit = prim | second;
				stop = hit && (!homing || ({second, prim} == BOTH_HIT));
			end else begin
				hit = prim;
				stop = prim;
			end
			return {stop, hit};
		end
	endfunction

	function automatic check_t check_axes(logic [VEC_W-1:0] acc, logic [AXES-1:0] moving,
			logic [AXES-1:0] negative, logic homing, cfg_t cfg);
		check_t res;
		logic [1:0] t;
		logic zmin_on;
		logic probe_test;
		begin
			res = '0;
			zmin_on = 1'b1;
			probe_test = 1'b0;
			if (!cfg.dual_axis_mask[2]) begin
				case (cfg.probe_mode)
					PROBE_SHARED: begin
						zmin_on = cfg.probe_enabled;
					end
					PROBE_SEPARATE: begin
						zmin_on = !cfg.probe_enabled;
					end
					default: begin
						zmin_on = 1'b1;
					end
				endcase
			end
			if (cfg.probe_mode == PROBE_SEPARATE) begin
				probe_test = cfg.probe_enabled;
			end
			if (cfg.checking_enabled || cfg.probe_enabled) begin
				if (moving[0]) begin
					if (negative[0]) begin
						t = side_test(acc[SW_XMIN], acc[SW_X2MIN], cfg.dual_axis_mask[0], homing);
						res.hits[SW_XMIN] = t[0];
					end else begin
						t = side_test(acc[SW_XMAX], acc[SW_X2MAX], cfg.dual_axis_mask[0], homing);
						res.hits[SW_XMAX] = t[0];
					end
					res.stop[0] = t[1];
				end
				if (moving[1]) begin
					if (negative[1]) begin
						t = side_test(acc[SW_YMIN], acc[SW_Y2MIN], cfg.dual_axis_mask[1], homing);
						res.hits[SW_YMIN] = t[0];
					end else begin
						t = side_test(acc[SW_YMAX], acc[SW_Y2MAX], cfg.dual_axis_mask[1], homing);
						res.hits[SW_YMAX] = t[0];
					end
					res.stop[1] = t[1];
				end
				if (moving[2]) begin
					if (negative[2]) begin
						if (zmin_on) begin
							t = side_test(acc[SW_ZMIN], acc[SW_Z2MIN], cfg.dual_axis_mask[2],
								homing);
							res.hits[SW_ZMIN] = t[0];
							res.stop[2] = t[1];
						end
						if (probe_test && acc[SW_PROBE]) begin
							res.hits[SW_PROBE] = 1'b1;
							res.stop[2] = 1'b1;
						end
					end else begin
						t = side_test(acc[SW_ZMAX], acc[SW_Z2MAX], cfg.dual_axis_mask[2], homing);
						res.hits[SW_ZMAX] = t[0];
						res.stop[2] = t[1];
					end
				end
			end
			return res;
		end
	endfunction

endpackage

FILE: rtl/core/limit_switch_monitor_top.sv
// Limit switch monitor top level: configuration registers, sticky hits and result register.
// Depends on lsm_pkg and lsm_filter.
`timescale 1ns / 1ps

// The block takes one poll tick per clock cycle while ready and gives one result for
// each tick, in the cycle after the tick is transferred. The tick is filtered, tested
// and written into a single result register; a new tick is taken whenever that register
// is empty or is being read in the same cycle, so the rate is set only by the output
// handshake. Configuration writes are always ready and take effect at the next tick.
module limit_switch_monitor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: switch_levels[12:0], axis_moving[15:13], axis_negative[18:16],
	// homing_dual[19], clear_hits[20], zero padding[23:21].
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: accepted_state[12:0], hit_flags[25:13], stop_axes[28:26],
	// zero padding[31:29].
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	lsm_pkg::cfg_t                  cfg_q;
	logic [lsm_pkg::VEC_W-1:0]      hits_q;
	logic                           m_tvalid_q;
	logic [31:0]                    m_tdata_q;
	logic                           in_xfer;
	logic [lsm_pkg::VEC_W-1:0]      levels;
	logic [lsm_pkg::AXES-1:0]       moving;
	logic [lsm_pkg::AXES-1:0]       negative;
	logic                           homing;
	logic                           clear;
	logic [lsm_pkg::VEC_W-1:0]      acc;
	lsm_pkg::check_t                chk;
	logic [lsm_pkg::VEC_W-1:0]      hits_next;

	assign levels   = s_tdata[12:0];
	assign moving   = s_tdata[15:13];
	assign negative = s_tdata[18:16];
	assign homing   = s_tdata[19];
	assign clear    = s_tdata[20];

	assign cfg_ready = 1'b1;
	assign s_tready = !m_tvalid_q || m_tready;
	assign in_xfer = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert_mask <= '0;
			cfg_q.checking_enabled <= 1'b0;
			cfg_q.probe_enabled <= 1'b0;
			cfg_q.dual_axis_mask <= '0;
			cfg_q.probe_mode <= lsm_pkg::PROBE_NONE;
			cfg_q.filter_on <= 1'b1;
			cfg_q.settle_ticks <= lsm_pkg::SETTLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (lsm_pkg::cfg_reg_t'(cfg_index))
				lsm_pkg::REG_INVERT_MASK: begin
					cfg_q.invert_mask <= cfg_data;
				end
				lsm_pkg::REG_CHECKING: begin
					cfg_q.checking_enabled <= cfg_data[0];
				end
				lsm_pkg::REG_PROBE_EN: begin
					cfg_q.probe_enabled <= cfg_data[0];
				end
				lsm_pkg::REG_DUAL_MASK: begin
					cfg_q.dual_axis_mask <= cfg_data[2:0];
				end
				lsm_pkg::REG_PROBE_MODE: begin
					cfg_q.probe_mode <= cfg_data[1:0];
				end
				lsm_pkg::REG_FILTER_ON: begin
					cfg_q.filter_on <= cfg_data[0];
				end
				lsm_pkg::REG_SETTLE_TICKS: begin
					cfg_q.settle_ticks <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	lsm_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (in_xfer),
		.levels (levels),
		.cfg    (cfg_q),
		.acc    (acc)
	);

	assign chk = lsm_pkg::check_axes(acc, moving, negative, homing, cfg_q);
	assign hits_next = (clear ? '0 : hits_q) | chk.hits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				hits_q <= hits_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			m_tdata_q <= {3'b000, chk.stop, hits_next, acc};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// Without a clear request, sticky hits are never lost.
	a_hits_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !clear) |=> ((hits_q & $past(hits_q)) == $past(hits_q)))
		else $error("sticky hit flags lost a bit without a clear");

	// A stopped X axis always has a recorded X hit.
	a_stop_x_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[26]) |-> (m_tdata[13] || m_tdata[17]))
		else $error("X stop without an X hit flag");

	// A stopped Z axis always has a recorded Z or probe hit.
	a_stop_z_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[28]) |-> (m_tdata[15] || m_tdata[16] || m_tdata[19]))
		else $error("Z stop without a Z or probe hit flag");

	// Every transferred tick shows up as a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (m_tvalid && (hits_q == m_tdata[25:13])))
		else $error("result missing or out of step with the sticky hits");

endmodule

FILE: rtl/core/lsm_filter.sv
// Stability filter for the switch vector of the limit switch monitor.
// Depends on lsm_pkg for widths and the configuration struct.
`timescale 1ns / 1ps

module lsm_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick,
	input  logic [lsm_pkg::VEC_W-1:0]         levels,
	input  lsm_pkg::cfg_t                     cfg,
	output logic [lsm_pkg::VEC_W-1:0]         acc
);

	logic [lsm_pkg::VEC_W-1:0]    previous_q;
	logic [lsm_pkg::VEC_W-1:0]    validated_q;
	logic [lsm_pkg::SETTLE_W-1:0] counter_q;
	logic [lsm_pkg::VEC_W-1:0]    sampled;
	logic [lsm_pkg::VEC_W-1:0]    validated_next;
	logic [lsm_pkg::SETTLE_W-1:0] counter_next;
	logic                         changed;

	assign sampled = levels ^ cfg.invert_mask;
	assign changed = previous_q != sampled;

	always_comb begin
		counter_next = counter_q;
		validated_next = validated_q;
		if (changed) begin
			counter_next = (cfg.settle_ticks == '0) ? lsm_pkg::SETTLE_W'(1) : cfg.settle_ticks;
		end else if (counter_q != '0) begin
			counter_next = counter_q - lsm_pkg::SETTLE_W'(1);
			if (counter_next == '0) begin
				validated_next = sampled;
			end
		end
	end

	assign acc = cfg.filter_on ? validated_next : sampled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_q <= '0;
			validated_q <= '0;
			counter_q <= '0;
		end else if (tick && cfg.filter_on) begin
			previous_q <= sampled;
			validated_q <= validated_next;
			counter_q <= counter_next;
		end
	end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for limit_switch_monitor_top: streams poll ticks, predicts each result.
// Depends on lsm_pkg and the limit switch monitor RTL only.
`timescale 1ns / 1ps

module testbench;
	import lsm_pkg::*;

	localparam logic [1:0] PROBE_UNUSED = 2'd3;
	localparam logic [VEC_W-1:0] ALL_SW = '1;
	localparam int PHASE_TICKS = 106;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [2:0]       pad;
		logic             clear_hits;
		logic             homing_dual;
		logic [AXES-1:0]  axis_negative;
		logic [AXES-1:0]  axis_moving;
		logic [VEC_W-1:0] switch_levels;
	} tick_t;

	typedef struct packed {
		logic [2:0]       pad;
		logic [AXES-1:0]  stop_axes;
		logic [VEC_W-1:0] hit_flags;
		logic [VEC_W-1:0] accepted_state;
	} stop_report_t;

	class stop_scoreboard;
		cfg_t cfg;
		logic [VEC_W-1:0] sampled;
		logic [VEC_W-1:0] previous;
		logic [VEC_W-1:0] validated;
		logic [VEC_W-1:0] sticky;
		logic [SETTLE_W-1:0] settle_cnt;
		stop_report_t awaited[$];
		int errors;

		function new();
			cfg = '0;
			cfg.filter_on = 1'b1;
			cfg.settle_ticks = SETTLE_RESET;
			sampled = '0;
			previous = '0;
			validated = '0;
			sticky = '0;
			settle_cnt = '0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [VEC_W-1:0] val);
			case (idx)
				REG_INVERT_MASK: cfg.invert_mask = val;
				REG_CHECKING: cfg.checking_enabled = val[0];
				REG_PROBE_EN: cfg.probe_enabled = val[0];
				REG_DUAL_MASK: cfg.dual_axis_mask = val[AXES-1:0];
				REG_PROBE_MODE: cfg.probe_mode = val[1:0];
				REG_FILTER_ON: cfg.filter_on = val[0];
				REG_SETTLE_TICKS: cfg.settle_ticks = val[SETTLE_W-1:0];
				default: ;
			endcase
		endfunction

		// Tests one switch pair and records the primary switch on a hit.
		function logic pair_stop(logic [VEC_W-1:0] acc, int prim, int second, logic dual,
				logic homing);
			logic p;
			logic s;
			p = acc[prim];
			s = acc[second];
			if (dual) begin
				if (p || s) begin
					sticky[prim] = 1'b1;
					return !homing || (p && s);
				end
				return 1'b0;
			end
			if (p) begin
				sticky[prim] = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void predict_tick(tick_t t);
			logic [VEC_W-1:0] acc;
			logic [AXES-1:0] stop;
			logic [1:0] pm;
			logic pen;
			logic zmin_on;
			stop_report_t r;
			if (t.clear_hits)
				sticky = '0;
			sampled = t.switch_levels ^ cfg.invert_mask;
			if (cfg.filter_on) begin
				if (previous != sampled) begin
					previous = sampled;
					settle_cnt = (cfg.settle_ticks == '0) ? 4'd1 : cfg.settle_ticks;
				end else if (settle_cnt != '0) begin
					settle_cnt = settle_cnt - 1'b1;
					if (settle_cnt == '0)
						validated = sampled;
				end
				acc = validated;
			end else begin
				acc = sampled;
			end
			pm = (cfg.probe_mode == PROBE_UNUSED) ? PROBE_NONE : cfg.probe_mode;
			pen = cfg.probe_enabled;
			stop = '0;
			if (cfg.checking_enabled || pen) begin
				if (t.axis_moving[0]) begin
					if (t.axis_negative[0])
						stop[0] = pair_stop(acc, SW_XMIN, SW_X2MIN, cfg.dual_axis_mask[0],
							t.homing_dual);
					else
						stop[0] = pair_stop(acc, SW_XMAX, SW_X2MAX, cfg.dual_axis_mask[0],
							t.homing_dual);
				end
				if (t.axis_moving[1]) begin
					if (t.axis_negative[1])
						stop[1] = pair_stop(acc, SW_YMIN, SW_Y2MIN, cfg.dual_axis_mask[1],
							t.homing_dual);
					else
						stop[1] = pair_stop(acc, SW_YMAX, SW_Y2MAX, cfg.dual_axis_mask[1],
							t.homing_dual);
				end
				if (t.axis_moving[2]) begin
					if (t.axis_negative[2]) begin
						if (cfg.dual_axis_mask[2])
							zmin_on = 1'b1;
						else if (pm == PROBE_SHARED)
							zmin_on = pen;
						else if (pm == PROBE_SEPARATE)
							zmin_on = !pen;
						else
							zmin_on = 1'b1;
						if (zmin_on)
							stop[2] = pair_stop(acc, SW_ZMIN, SW_Z2MIN, cfg.dual_axis_mask[2],
								t.homing_dual);
						if (pm == PROBE_SEPARATE && pen)
							stop[2] = pair_stop(acc, SW_PROBE, SW_PROBE, 1'b0, t.homing_dual)
								| stop[2];
					end else begin
						stop[2] = pair_stop(acc, SW_ZMAX, SW_Z2MAX, cfg.dual_axis_mask[2],
							t.homing_dual);
					end
				end
			end
			r = '0;
			r.accepted_state = acc;
			r.hit_flags = sticky;
			r.stop_axes = stop;
			awaited.push_back(r);
		endfunction

		task report(string msg);
			$display("%0t ns mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(stop_report_t got);
			stop_report_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result %h with no tick waiting", got));
				return;
			end
			want = awaited.pop_front();
			if (got.accepted_state !== want.accepted_state)
				report($sformatf("accepted_state %h, predicted %h", got.accepted_state,
					want.accepted_state));
			if (got.hit_flags !== want.hit_flags)
				report($sformatf("hit_flags %h, predicted %h", got.hit_flags, want.hit_flags));
			if (got.stop_axes !== want.stop_axes)
				report($sformatf("stop_axes %b, predicted %b", got.stop_axes, want.stop_axes));
		endtask

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [12:0] cfg_data;

	stop_scoreboard sb = new();
	int gap_max = 0;
	int stall_max = 0;
	logic hold_req = 1'b0;

	limit_switch_monitor_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.predict_tick(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// The result side stalls at random and, on request, holds off for a long stretch.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = (stall_max > 0) ? $urandom_range(stall_max, 0) : 0;
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic tick_t make_tick(logic [VEC_W-1:0] trig, logic [AXES-1:0] mov,
			logic [AXES-1:0] neg, logic homing, logic clr);
		tick_t t;
		t = '0;
		t.switch_levels = trig ^ sb.cfg.invert_mask;
		t.axis_moving = mov;
		t.axis_negative = neg;
		t.homing_dual = homing;
		t.clear_hits = clr;
		return t;
	endfunction

	function automatic logic [VEC_W-1:0] sparse_vec();
		logic [VEC_W-1:0] v;
		int n;
		v = '0;
		if ($urandom_range(3, 0) == 0) begin
			v = VEC_W'($urandom);
		end else begin
			n = $urandom_range(3, 0);
			repeat (n) v[$urandom_range(VEC_W-1, 0)] = 1'b1;
		end
		return v;
	endfunction

	task automatic send_tick(tick_t t);
		int gap;
		gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			s_tdata = 24'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = t;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_reg(cfg_reg_t idx, logic [12:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure(logic [VEC_W-1:0] inv, logic chk, logic pen, logic [AXES-1:0] dual,
			logic [1:0] pmode, logic filt, logic [SETTLE_W-1:0] settle);
		drain();
		set_reg(REG_INVERT_MASK, inv);
		set_reg(REG_CHECKING, 13'(chk));
		set_reg(REG_PROBE_EN, 13'(pen));
		set_reg(REG_DUAL_MASK, 13'(dual));
		set_reg(REG_PROBE_MODE, 13'(pmode));
		set_reg(REG_FILTER_ON, 13'(filt));
		set_reg(REG_SETTLE_TICKS, 13'(settle));
	endtask

	initial begin
		int n;
		int run_len;
		logic noise;
		logic [VEC_W-1:0] trig;
		logic [VEC_W-1:0] v;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: live vector, plain switches, both travel directions.
		configure('0, 1'b1, 1'b0, 3'b000, PROBE_NONE, 1'b0, SETTLE_RESET);
		send_tick(make_tick('0, 3'b111, 3'b111, 1'b0, 1'b0));
		send_tick(make_tick(ALL_SW, 3'b111, 3'b111, 1'b0, 1'b0));
		send_tick(make_tick(ALL_SW, 3'b111, 3'b000, 1'b0, 1'b0));
		send_tick(make_tick('0, 3'b000, 3'b000, 1'b0, 1'b1));
		send_tick(make_tick(ALL_SW, 3'b111, 3'b111, 1'b1, 1'b1));

		// Paired switches on every axis, all switches active low.
		configure(ALL_SW, 1'b1, 1'b0, 3'b111, PROBE_NONE, 1'b0, SETTLE_RESET);
		send_tick(make_tick(13'(1) << SW_XMIN, 3'b001, 3'b001, 1'b1, 1'b1));
		send_tick(make_tick((13'(1) << SW_XMIN) | (13'(1) << SW_X2MIN), 3'b001, 3'b001,
			1'b1, 1'b0));
		send_tick(make_tick(13'(1) << SW_Y2MAX, 3'b010, 3'b000, 1'b0, 1'b0));
		send_tick(make_tick((13'(1) << SW_ZMAX) | (13'(1) << SW_Z2MAX), 3'b100, 3'b000,
			1'b1, 1'b0));
		send_tick(make_tick(13'(1) << SW_Z2MIN, 3'b100, 3'b100, 1'b1, 1'b0));

		// Separate probe pin with the probe enabled and checking off.
		configure('0, 1'b0, 1'b1, 3'b000, PROBE_SEPARATE, 1'b0, SETTLE_RESET);
		send_tick(make_tick(13'(1) << SW_PROBE, 3'b100, 3'b100, 1'b0, 1'b1));
		send_tick(make_tick(13'(1) << SW_ZMIN, 3'b100, 3'b100, 1'b0, 1'b0));
		send_tick(make_tick(13'(1) << SW_PROBE, 3'b100, 3'b000, 1'b0, 1'b0));

		configure('0, 1'b0, 1'b1, 3'b100, PROBE_SEPARATE, 1'b0, SETTLE_RESET);
		send_tick(make_tick((13'(1) << SW_ZMIN) | (13'(1) << SW_PROBE), 3'b100, 3'b100,
			1'b1, 1'b1));

		configure('0, 1'b1, 1'b0, 3'b100, PROBE_SEPARATE, 1'b0, SETTLE_RESET);
		send_tick(make_tick((13'(1) << SW_Z2MIN) | (13'(1) << SW_PROBE), 3'b100, 3'b100,
			1'b0, 1'b1));

		// Shared probe pin, then the unused probe mode, then checking off.
		configure('0, 1'b1, 1'b0, 3'b000, PROBE_SHARED, 1'b0, SETTLE_RESET);
		send_tick(make_tick(13'(1) << SW_ZMIN, 3'b100, 3'b100, 1'b0, 1'b1));
		configure('0, 1'b1, 1'b1, 3'b000, PROBE_SHARED, 1'b0, SETTLE_RESET);
		send_tick(make_tick(13'(1) << SW_ZMIN, 3'b100, 3'b100, 1'b0, 1'b0));
		configure('0, 1'b1, 1'b0, 3'b000, PROBE_UNUSED, 1'b0, SETTLE_RESET);
		send_tick(make_tick(13'(1) << SW_ZMIN, 3'b100, 3'b100, 1'b0, 1'b1));
		configure('0, 1'b0, 1'b0, 3'b000, PROBE_NONE, 1'b0, SETTLE_RESET);
		send_tick(make_tick(ALL_SW, 3'b111, 3'b101, 1'b0, 1'b0));

		// Filter with a settle count of zero, which behaves as one.
		configure('0, 1'b1, 1'b0, 3'b000, PROBE_NONE, 1'b1, 4'd0);
		send_tick(make_tick(13'(1) << SW_XMAX, 3'b001, 3'b000, 1'b0, 1'b1));
		send_tick(make_tick(13'(1) << SW_XMAX, 3'b001, 3'b000, 1'b0, 1'b0));
		send_tick(make_tick(13'(1) << SW_XMAX, 3'b001, 3'b000, 1'b0, 1'b0));
		send_tick(make_tick('0, 3'b001, 3'b000, 1'b0, 1'b0));

		// Random phases: switch vectors held for runs near the settle count, with glitches.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: configure(ALL_SW, 1'b1, 1'b1, 3'b111, PROBE_UNUSED, 1'b1, 4'd15);
				1: configure('0, 1'b0, 1'b0, 3'b000, PROBE_NONE, 1'b0, 4'd0);
				default: configure(VEC_W'($urandom), $urandom_range(3, 0) != 0,
					1'($urandom_range(1, 0)), 3'($urandom_range(7, 0)),
					2'($urandom_range(3, 0)), $urandom_range(3, 0) != 0,
					($urandom_range(3, 0) == 0) ? 4'($urandom_range(15, 0))
						: 4'($urandom_range(4, 1)));
			endcase
			gap_max = (p % 3 == 1) ? 0 : 14;
			stall_max = (p % 4 == 2) ? 0 : 14;
			if (p == 4)
				hold_req = 1'b1;
			n = 0;
			while (n < PHASE_TICKS) begin
				run_len = $urandom_range(int'(sb.cfg.settle_ticks) + 4, 1);
				noise = ($urandom_range(7, 0) == 0);
				trig = sparse_vec();
				for (int k = 0; k < run_len && n < PHASE_TICKS; k++) begin
					if (noise || $urandom_range(9, 0) == 0)
						v = sparse_vec();
					else
						v = trig;
					send_tick(make_tick(v, 3'($urandom_range(7, 0)), 3'($urandom_range(7, 0)),
						1'($urandom_range(1, 0)), $urandom_range(15, 0) == 0));
					n++;
				end
			end
		end

		drain();
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/lsm_pkg.sv
rtl/core/lsm_filter.sv
rtl/core/limit_switch_monitor_top.sv
tb/testbench.sv
